>>> hw/rtl/gini_pkg.sv
// ============================================================================
// gini_pkg: shared types and constants of the Gini impurity tracker
// Item and result beats, operation and status codes, the internal command
// passed from the front end to the back end, and the back-end state type.
// ============================================================================
`default_nettype none

package gini_pkg;

  localparam int OP_W     = 2;
  localparam int CHILD_W  = 3;
  localparam int LABEL_W  = 8;
  localparam int GINI_W   = 16;
  localparam int TOTAL_W  = 16;
  localparam int CFG_W    = 5;
  localparam int SUM_BITS = 64;
  localparam int Q_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0]  NUM_CLASSES_RESET = 5'd16;
  localparam logic [Q_BITS-1:0] Q_ONES            = 16'hFFFF;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHILD_W-1:0] child;
    logic [LABEL_W-1:0] class_label;
  } item_t;

  typedef struct packed {
    logic [CHILD_W-1:0] node;
    logic [GINI_W-1:0]  gini_q16;
    logic [TOTAL_W-1:0] node_total;
    status_t            status;
  } result_t;

  // What the back end has to do with one item.
  typedef enum logic [2:0] {
    K_ADD,
    K_REMOVE,
    K_CLEAR,
    K_QUERY,
    K_RANGE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHILD_W-1:0] child;
    logic [LABEL_W-1:0] label;
    logic               counted;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_UPDATE,
    BK_WIPE,
    BK_SQUARE,
    BK_NUMER,
    BK_DIV_START,
    BK_DIV_WAIT,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/gini_fifo.sv
// ============================================================================
// gini_fifo: small synchronous queue
// Holds a few beats between two sides so that each can stall on its own.
// ============================================================================
`default_nettype none

module gini_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gini_div.sv
// ============================================================================
// gini_div: restoring fraction divider
// Forms floor(num * 2^16 / den) one quotient bit per cycle; a numerator at or
// above the denominator saturates the quotient to all ones at once.
// ============================================================================
`default_nettype none

module gini_div
  import gini_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [Q_BITS-1:0]  quot
);

  localparam int SW = $clog2(Q_BITS + 1);

  logic          active;
  logic [SW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_dif;
  logic          fits;

  // The remainder stays below the denominator, so one shift never overflows.
  assign rem_sh  = {rem, 1'b0};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign fits    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den) begin
          done <= 1'b1;
        end else begin
          active <= 1'b1;
          cnt    <= SW'(Q_BITS);
        end
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quot  <= (num >= den) ? Q_ONES : '0;
    end else if (active) begin
      rem  <= fits ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
      quot <= {quot[Q_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gini_front.sv
// ============================================================================
// gini_front: item intake and classification
// Holds the class-count register, sorts each accepted item into a command
// and queues it for the back end.
// ============================================================================
`default_nettype none

module gini_front
  import gini_pkg::*;
#(
  parameter int MAX_CHILDREN = 8,
  parameter int MAX_CLASSES  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire item_t            item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             back_ready,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  wire logic             cmd_pop
);

  logic [CFG_W-1:0]    num_classes;
  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;
  logic                q_full;
  logic                q_empty;
  logic                accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NUM_CLASSES_RESET;
    end else if (cfg_valid) begin
      num_classes <= cfg_data;
    end
  end

  // Nothing enters while the back end is still wiping its memories.
  assign full   = q_full || !back_ready;
  assign accept = push && !full;

  always_comb begin
    cmd_in.child   = item.child;
    cmd_in.label   = item.class_label;
    cmd_in.counted = (item.class_label < LABEL_W'(num_classes)) &&
                     (int'(item.class_label) < MAX_CLASSES);
    if (int'(item.child) >= MAX_CHILDREN) begin
      cmd_in.kind = K_RANGE;
    end else begin
      case (item.op)
        OP_ADD:    cmd_in.kind = K_ADD;
        OP_REMOVE: cmd_in.kind = K_REMOVE;
        OP_CLEAR:  cmd_in.kind = K_CLEAR;
        default:   cmd_in.kind = K_QUERY;
      endcase
    end
  end

  gini_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_bits),
    .empty   (q_empty)
  );

  assign cmd       = cmd_t'(cmd_bits);
  assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

>>> hw/rtl/gini_back.sv
// ============================================================================
// gini_back: count update and impurity evaluation
// Sequencer over the class-count and node memories, the squaring multiplier
// and the fraction divider; produces one result beat per command.
// ============================================================================
`default_nettype none

module gini_back
  import gini_pkg::*;
#(
  parameter int MAX_CHILDREN = 8,
  parameter int MAX_CLASSES  = 16,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      ready,
  input  wire logic res_full,
  output logic      res_push,
  output result_t   res
);

  localparam int TOTAL = MAX_CHILDREN * MAX_CLASSES;
  localparam int AW    = $clog2(TOTAL);
  localparam int CH_W  = $clog2(MAX_CHILDREN);
  localparam int CL_W  = $clog2(MAX_CLASSES);
  localparam int DW    = 2 * COUNT_BITS;
  localparam int NW    = COUNT_BITS + SUM_BITS;

  back_state_t state, state_next;

  logic [COUNT_BITS-1:0] cls_mem [TOTAL];
  logic [NW-1:0]         node_mem [MAX_CHILDREN];
  logic [COUNT_BITS-1:0] cls_rd;
  logic [NW-1:0]         node_rd;

  logic [AW-1:0]   cnt;
  kind_t           kind_r;
  logic            counted_r;
  logic [CHILD_W-1:0] child_r;
  logic [AW-1:0]   base_r;
  logic [AW-1:0]   addr_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [SUM_BITS-1:0]   s_r;
  status_t         status_r;
  logic [DW-1:0]   d_r;
  logic [DW-1:0]   num_r;
  logic [GINI_W-1:0] gini_r;

  logic [CH_W-1:0] head_child;
  logic [AW-1:0]   head_base;
  logic [AW-1:0]   head_addr;

  logic [COUNT_BITS-1:0] n_cur, n_new, c_new;
  logic [SUM_BITS-1:0]   s_cur, s_new;
  status_t               upd_st;
  logic                  upd_node_we, upd_cls_we;

  logic                  cls_we, node_we;
  logic [AW-1:0]         cls_waddr;
  logic [COUNT_BITS-1:0] cls_wdata;
  logic [CH_W-1:0]       node_waddr;
  logic [NW-1:0]         node_wdata;

  logic              div_start, div_done;
  logic [Q_BITS-1:0] div_quot;

  // Memory address of the command at the head of the queue.
  assign head_child = CH_W'(cmd.child);
  assign head_base  = AW'(head_child) * AW'(MAX_CLASSES);
  assign head_addr  = cmd.counted ? head_base + AW'(CL_W'(cmd.label)) : head_base;

  // Count update for add, remove and clear; a refused item leaves everything alone.
  assign n_cur = node_rd[SUM_BITS +: COUNT_BITS];
  assign s_cur = node_rd[SUM_BITS-1:0];

  always_comb begin
    n_new       = n_cur;
    s_new       = s_cur;
    c_new       = cls_rd;
    upd_st      = ST_OK;
    upd_node_we = 1'b0;
    upd_cls_we  = 1'b0;
    case (kind_r)
      K_ADD: begin
        if (n_cur == '1) begin
          upd_st = ST_OVER;
        end else begin
          n_new       = n_cur + 1'b1;
          upd_node_we = 1'b1;
          if (counted_r) begin
            s_new      = s_cur + SUM_BITS'({cls_rd, 1'b1});
            c_new      = cls_rd + 1'b1;
            upd_cls_we = 1'b1;
          end
        end
      end
      K_REMOVE: begin
        if (n_cur == '0 || (counted_r && cls_rd == '0)) begin
          upd_st = ST_UNDER;
        end else begin
          n_new       = n_cur - 1'b1;
          upd_node_we = 1'b1;
          if (counted_r) begin
            s_new      = s_cur - SUM_BITS'({cls_rd, 1'b0}) + SUM_BITS'(1);
            c_new      = cls_rd - 1'b1;
            upd_cls_we = 1'b1;
          end
        end
      end
      K_CLEAR: begin
        n_new       = '0;
        s_new       = '0;
        upd_node_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_INIT:      if (cnt == AW'(TOTAL - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == K_RANGE) ? BK_EMIT : BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (kind_r == K_CLEAR) begin
          state_next = BK_WIPE;
        end else if (n_new == '0) begin
          state_next = BK_EMIT;
        end else begin
          state_next = BK_SQUARE;
        end
      end
      BK_WIPE:      if (cnt == AW'(MAX_CLASSES - 1)) state_next = BK_EMIT;
      BK_SQUARE:    state_next = BK_NUMER;
      BK_NUMER:     state_next = BK_DIV_START;
      BK_DIV_START: state_next = BK_DIV_WAIT;
      BK_DIV_WAIT:  if (div_done) state_next = BK_EMIT;
      BK_EMIT:      if (!res_full) state_next = BK_IDLE;
      default:      state_next = BK_IDLE;
    endcase
  end

  // Outputs and memory write ports.
  always_comb begin
    cmd_pop    = 1'b0;
    ready      = 1'b1;
    cls_we     = 1'b0;
    cls_waddr  = addr_r;
    cls_wdata  = '0;
    node_we    = 1'b0;
    node_waddr = CH_W'(child_r);
    node_wdata = {n_new, s_new};
    div_start  = 1'b0;
    res_push   = 1'b0;
    case (state)
      BK_INIT: begin
        ready      = 1'b0;
        cls_we     = 1'b1;
        cls_waddr  = cnt;
        node_we    = (cnt < AW'(MAX_CHILDREN));
        node_waddr = cnt[CH_W-1:0];
        node_wdata = '0;
      end
      BK_IDLE: begin
        cmd_pop = cmd_valid;
      end
      BK_UPDATE: begin
        node_we   = upd_node_we;
        cls_we    = upd_cls_we;
        cls_wdata = c_new;
      end
      BK_WIPE: begin
        cls_we    = 1'b1;
        cls_waddr = base_r + cnt;
      end
      BK_DIV_START: begin
        div_start = 1'b1;
      end
      BK_EMIT: begin
        res_push = !res_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == BK_INIT || state == BK_WIPE) begin
        cnt <= cnt + 1'b1;
      end else if (state == BK_UPDATE) begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (cmd_pop) begin
      cls_rd  <= cls_mem[head_addr];
      node_rd <= node_mem[head_child];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          kind_r    <= cmd.kind;
          counted_r <= cmd.counted;
          child_r   <= cmd.child;
          base_r    <= head_base;
          addr_r    <= head_addr;
          n_r       <= '0;
          status_r  <= ST_OK;
        end
      end
      BK_UPDATE: begin
        n_r      <= n_new;
        s_r      <= s_new;
        status_r <= upd_st;
      end
      BK_SQUARE: begin
        d_r <= DW'(n_r) * DW'(n_r);
      end
      BK_NUMER: begin
        num_r <= (SUM_BITS'(d_r) >= s_r) ? DW'(SUM_BITS'(d_r) - s_r) : '0;
      end
      BK_DIV_WAIT: begin
        if (div_done) begin
          gini_r <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

  gini_div #(
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (d_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // An empty node reads as zero impurity, with the empty status unless the item was refused.
  always_comb begin
    res.node       = child_r;
    res.gini_q16   = (n_r == '0) ? '0 : gini_r;
    res.node_total = TOTAL_W'(n_r);
    res.status     = (n_r == '0 && status_r == ST_OK) ? ST_EMPTY : status_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/gini_impurity_tracker.sv
// ============================================================================
// gini_impurity_tracker: per-node class counts with Gini impurity results
// Top level: item queue and classifier, update/evaluate back end, result
// queue.
// ============================================================================
// Each item adds one labelled observation to a child node, removes one,
// clears the node or only reports it; every item gives one result beat with
// the node's Gini impurity 1 - sum(c^2)/n^2 as an unsigned Q0.16 fraction
// (truncated, saturated at 0xFFFF), the node total and a status. Both sides
// look like a queue: push items while full is low, pop results while empty
// is low. The back end works on one item at a time; an add, remove or query
// that leaves the node non-empty runs the 16-step restoring divider that
// forms the fraction, and a clear runs the sweep that zeroes the node's row
// of class counts one entry per cycle. A two-beat queue on each side lets
// items wait while the back end is busy and lets the back end move on while
// a finished result is still waiting to be popped. After reset the block
// wipes all MAX_CHILDREN * MAX_CLASSES class-count entries (128 with the
// default parameters) and the node totals, holding full high meanwhile;
// configuration writes are taken at any time. The num_classes register (reset
// 16) should be written only while the block is idle. Labels at or above
// num_classes (or MAX_CLASSES) only change the node total.
`default_nettype none

module gini_impurity_tracker
  import gini_pkg::*;
#(
  parameter int MAX_CHILDREN = 8,
  parameter int MAX_CLASSES  = 16,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire item_t            item,
  output logic                  empty,
  input  wire logic             pop,
  output result_t               result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  logic    back_ready;
  logic    res_full;
  logic    res_push;
  result_t res;
  logic [$bits(result_t)-1:0] res_bits;

  // Front end: registers the class count and classifies items into commands.
  gini_front #(
    .MAX_CHILDREN (MAX_CHILDREN),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .back_ready (back_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // Back end: updates counts and computes the impurity of the touched node.
  gini_back #(
    .MAX_CHILDREN (MAX_CHILDREN),
    .MAX_CLASSES  (MAX_CLASSES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ready     (back_ready),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue: the oldest finished beat sits on the result port.
  gini_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = result_t'(res_bits);

endmodule

`default_nettype wire

>>> hw/rtl/gini_checker.sv
// ============================================================================
// gini_checker: port-level checks of the Gini impurity tracker
// Watches the queue ports and result fields; bound to the top level.
// ============================================================================
`default_nettype none

module gini_checker
  import gini_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    full,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result
);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'({COUNT_BITS{1'b1}});

  // A result beat that is not popped stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result beat changed or vanished while not popped");

  // After reset no result is pending and no item is taken during the wipe.
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && full))
    else $error("queues not empty and blocked after reset");

  // An empty status always describes an empty node.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_EMPTY) |->
      (result.gini_q16 == '0 && result.node_total == '0))
    else $error("empty status with nonzero impurity or total");

  // A refused add only happens on a node at the top of the count range.
  a_over: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_OVER) |-> (result.node_total == TOTAL_MAX))
    else $error("overflow status on a node that is not full");

endmodule

bind gini_impurity_tracker gini_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_gini_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

>>> dv/gini_impurity_tracker_test.sv
// ============================================================================
// gini_impurity_tracker_test: self-checking bench for the Gini impurity tracker
// Drives add, remove, clear and query items through the item queue, keeps its
// own copy of the per-node class counts to predict every result beat, and
// checks each popped beat field by field, across several class settings.
// ============================================================================
`default_nettype none

module gini_impurity_tracker_test;
  import gini_pkg::*;

  localparam int MAX_CHILDREN = 8;
  localparam int MAX_CLASSES  = 16;
  localparam int COUNT_BITS   = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // The package names three operations; the fourth code only reports a node.
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam int MAX_IDLE       = 19;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_ITEMS    = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  item_t              item = '0;
  logic               empty;
  logic               pop = 1'b0;
  result_t            result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Shadow copy of the block's counting state. It is updated in the order in
  // which item beats are accepted, so it always matches what the block holds
  // once that item has been processed.
  logic [COUNT_BITS-1:0] class_tally [MAX_CHILDREN][MAX_CLASSES] = '{default: '0};
  logic [COUNT_BITS-1:0] node_tally [MAX_CHILDREN] = '{default: '0};
  logic [63:0]           square_tally [MAX_CHILDREN] = '{default: '0};
  logic [CFG_W-1:0]      class_setting = NUM_CLASSES_RESET;

  // Results predicted for accepted items, oldest first.
  result_t expected_results [$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  gini_impurity_tracker #(
    .MAX_CHILDREN(MAX_CHILDREN),
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fraction num/den in Q0.16, truncated, formed the same way as a restoring
  // divider would. A numerator that reaches the denominator saturates.
  function automatic logic [Q_BITS-1:0] q16_fraction(input logic [63:0] num,
                                                     input logic [63:0] den);
    logic [63:0]       rem;
    logic [Q_BITS-1:0] quo;
    rem = num;
    quo = '0;
    if (num >= den) return Q_ONES;
    for (int i = 0; i < Q_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Applies one item to the shadow counts and returns the result beat the
  // block must produce for it.
  function automatic result_t update_node_gini(input item_t it);
    result_t               res;
    int                    eff;
    bit                    counted;
    int                    cls;
    int                    nd;
    logic [COUNT_BITS-1:0] cnt;
    logic [63:0]           n;
    logic [63:0]           s;
    logic [63:0]           d;
    status_t               st;
    nd = it.child;
    eff = (class_setting < MAX_CLASSES) ? class_setting : MAX_CLASSES;
    counted = (it.class_label < eff);
    cls = counted ? it.class_label : 0;
    cnt = class_tally[nd][cls];
    st = ST_OK;
    case (it.op)
      OP_ADD: begin
        if (node_tally[nd] == COUNT_MAX) begin
          st = ST_OVER;
        end else begin
          node_tally[nd] = node_tally[nd] + 1'b1;
          if (counted) begin
            square_tally[nd] = square_tally[nd] + 2 * cnt + 1;
            class_tally[nd][cls] = cnt + 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (node_tally[nd] == 0 || (counted && cnt == 0)) begin
          st = ST_UNDER;
        end else begin
          node_tally[nd] = node_tally[nd] - 1'b1;
          if (counted) begin
            square_tally[nd] = square_tally[nd] - (2 * cnt - 1);
            class_tally[nd][cls] = cnt - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < MAX_CLASSES; k++) class_tally[nd][k] = '0;
        node_tally[nd] = '0;
        square_tally[nd] = '0;
      end
      default: begin
      end
    endcase
    n = node_tally[nd];
    s = square_tally[nd];
    res.node = it.child;
    res.node_total = node_tally[nd];
    if (n == 0) begin
      res.gini_q16 = '0;
      if (st == ST_OK) st = ST_EMPTY;
    end else begin
      d = n * n;
      res.gini_q16 = q16_fraction((s <= d) ? d - s : 64'd0, d);
    end
    res.status = st;
    return res;
  endfunction

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  // Sends one item beat. Push stays high into the next item when that one
  // has no gap, so push is never lowered and raised in the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHILD_W-1:0] child,
                           input logic [LABEL_W-1:0] label);
    item_t it;
    int    gap;
    it.op = op;
    it.child = child;
    it.class_label = label;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    expected_results.insert(expected_results.size(), update_node_gini(it));
  endtask

  // Stops sending and waits until every predicted result has been popped.
  // Every item yields exactly one result, so the block is idle afterwards.
  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_num_classes(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    class_setting = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int exp_val, input int act_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s expected %0d actual %0d", $realtime, what, exp_val,
               act_val);
  endtask

  // Result side: each beat waits out a random stall, then pop is held high
  // until a beat is taken. The beat on the result port before the edge is the
  // one accepted, so it is read right after the edge.
  always begin
    int      stall;
    result_t exp_res;
    wait (rst == 1'b0);
    stall = draw_gap();
    if (stall > 0) begin
      pop <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    pop <= 1'b1;
    do @(posedge clk); while (empty !== 1'b0);
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result beat, node", -1, result.node);
    end else begin
      exp_res = expected_results.pop_front();
      if (result.node !== exp_res.node)
        report_mismatch("node", exp_res.node, result.node);
      if (result.gini_q16 !== exp_res.gini_q16)
        report_mismatch("gini_q16", exp_res.gini_q16, result.gini_q16);
      if (result.node_total !== exp_res.node_total)
        report_mismatch("node_total", exp_res.node_total, result.node_total);
      if (result.status !== exp_res.status)
        report_mismatch("status", exp_res.status, result.status);
    end
  end

  // The watchdog counts cycles in which no beat moves on any channel. The
  // longest legal quiet stretch is the memory wipe after reset or a clear
  // with both sides idling, far below the limit.
  always @(posedge clk) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Basic operations at the reset class setting: queries and refused removes
  // on an empty node, counted and uncounted labels at the label edges, a
  // node made only of uncounted labels (which saturates), clears, and a
  // successful remove that leaves the node empty.
  task automatic test_basic_operations();
    send_item(OP_QUERY,  3'd0, 8'd0);
    send_item(OP_REMOVE, 3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd15);
    send_item(OP_ADD,    3'd0, 8'd16);
    send_item(OP_REMOVE, 3'd0, 8'd3);
    send_item(OP_REMOVE, 3'd0, 8'd255);
    send_item(OP_REMOVE, 3'd0, 8'd15);
    send_item(OP_QUERY,  3'd0, 8'd77);
    send_item(OP_ADD,    3'd7, 8'd255);
    send_item(OP_ADD,    3'd7, 8'd200);
    send_item(OP_CLEAR,  3'd7, 8'd0);
    send_item(OP_CLEAR,  3'd7, 8'd255);
    send_item(OP_REMOVE, 3'd7, 8'd255);
    send_item(OP_REMOVE, 3'd0, 8'd0);
    send_item(OP_REMOVE, 3'd0, 8'd0);
  endtask

  // Class setting changes. With zero classes nothing is counted; a setting
  // above the class count is clamped; narrowing the setting keeps counts of
  // classes no longer counted in the square sum, which can exceed n squared.
  task automatic test_class_settings();
    write_num_classes(5'd0);
    send_item(OP_ADD,    3'd1, 8'd0);
    send_item(OP_ADD,    3'd1, 8'd0);
    write_num_classes(5'd1);
    send_item(OP_ADD,    3'd1, 8'd0);
    send_item(OP_REMOVE, 3'd1, 8'd5);
    write_num_classes(5'd31);
    send_item(OP_ADD,    3'd2, 8'd15);
    send_item(OP_ADD,    3'd2, 8'd16);
    write_num_classes(5'd2);
    send_item(OP_REMOVE, 3'd2, 8'd15);
    send_item(OP_REMOVE, 3'd2, 8'd16);
    write_num_classes(NUM_CLASSES_RESET);
  endtask

  // Random traffic in phases, one class setting per phase. Most items are
  // adds and removes with labels near the counted range so that nodes build
  // up and removes mostly succeed; the rest are clears, queries and items
  // with fully random fields. Idling is switched on and off in stretches.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings [5];
    int               roll;
    int               eff;
    logic [OP_W-1:0]  op;
    logic [LABEL_W-1:0] label;
    settings = '{5'd1, 5'd31, 5'($urandom_range(0, 31)), 5'd0, 5'd16};
    foreach (settings[p]) begin
      write_num_classes(settings[p]);
      eff = (class_setting < MAX_CLASSES) ? class_setting : MAX_CLASSES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 99);
        label = LABEL_W'($urandom_range(0, eff + 1));
        if (roll < 50)      op = OP_ADD;
        else if (roll < 80) op = OP_REMOVE;
        else if (roll < 86) op = OP_CLEAR;
        else if (roll < 90) op = OP_QUERY;
        else begin
          op = OP_W'($urandom());
          label = LABEL_W'($urandom());
        end
        send_item(op, CHILD_W'($urandom_range(0, MAX_CHILDREN - 1)), label);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_operations();
    test_class_settings();
    test_random_traffic();
    wait_for_results();
    // Any stray beat that shows up after the last one is still caught here.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/gini_pkg.sv
hw/rtl/gini_fifo.sv
hw/rtl/gini_div.sv
hw/rtl/gini_front.sv
hw/rtl/gini_back.sv
hw/rtl/gini_impurity_tracker.sv
hw/rtl/gini_checker.sv
dv/gini_impurity_tracker_test.sv
